>>> hw/rtl/pcpa_pkg.sv
// Shared types and codes of the per-CPU page allocator.
package pcpa_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CPU_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SUM_W    = ADDR_W + 1;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNUSED   = 2'd3;

  localparam logic REG_REGION_START = 1'b0;
  localparam logic REG_REGION_STOP  = 1'b1;

  typedef struct packed {
    logic             sub;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             ge;
    logic [SUM_W-1:0] res;
  } alu_rsp_t;

endpackage

>>> hw/rtl/pcpa_alu.sv
// Shared 33-bit add/subtract unit with unsigned compare flag.
module pcpa_alu
  import pcpa_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [SUM_W:0] sum;

  always_comb begin
    sum = {1'b0, req_i.a} + {1'b0, (req_i.sub ? ~req_i.b : req_i.b)}
        + {{SUM_W{1'b0}}, req_i.sub};
    rsp_o.ge  = sum[SUM_W];
    rsp_o.res = sum[SUM_W-1:0];
  end

endmodule

>>> hw/rtl/per_cpu_page_allocator_top.sv
// Top level of the per-CPU free-list page allocator.
//
// Requests enter on the s_axis channel: tuser carries the kind (allocate,
// free to own CPU, seed free round-robin), tdata the CPU number and the
// byte address of the page being freed. Each request gives one response on
// the m_axis channel: the allocated page address and a status code. The user
// must set region start and stop via the cfg write port while idle (unchecked).
//
// A small sequencer runs the requests through one shared 33-bit subtract/add
// unit and a link memory with registered read. Free and seed free go through
// three subtractions, a range compare, the push and the response load; a
// rejected address skips the push. Allocate runs head select, link read, head
// update with the address add and response load; an empty pool skips the link
// read and head update, and the unused kind only loads the response. A new
// request is taken in the cycle after the response is loaded, while that
// response may still wait in the output register. A stalled receiver holds the
// finished response in the sequencer until the output register frees up. Reset
// empties all lists at once and clears the round-robin pointer; the link
// memory needs no clearing.
module per_cpu_page_allocator_top
  import pcpa_pkg::*;
#(
  parameter int unsigned CPU_COUNT  = 8,
  parameter int unsigned PAGE_COUNT = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // cpu[2:0], address[34:3], zero pad
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // page_address[31:0], status[33:32], zero pad
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned SEL_W  = $clog2(CPU_COUNT);
  localparam int unsigned PG_W   = $clog2(PAGE_COUNT);
  localparam int unsigned LINK_W = $clog2(PAGE_COUNT + 1);
  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(PAGE_COUNT);
  localparam logic [63:0] PAGE_LIMIT = 64'(PAGE_COUNT) << PAGE_SHIFT;
  localparam logic [SUM_W-1:0] PAGE_MASK = SUM_W'((64'd1 << PAGE_SHIFT) - 64'd1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CK_START = 4'd1;
  localparam logic [3:0] S_CK_STOP  = 4'd2;
  localparam logic [3:0] S_CK_BASE  = 4'd3;
  localparam logic [3:0] S_CK_RANGE = 4'd4;
  localparam logic [3:0] S_PUSH     = 4'd5;
  localparam logic [3:0] S_SEL      = 4'd6;
  localparam logic [3:0] S_POP_RD   = 4'd7;
  localparam logic [3:0] S_POP_WB   = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  function automatic logic [SEL_W-1:0] cpu_mod(input logic [CPU_W-1:0] c);
    logic [4:0] v;
    v = {2'b00, c};
    for (int k = 0; k < 4; k++) begin
      if (v >= 5'(CPU_COUNT)) begin
        v = v - 5'(CPU_COUNT);
      end
    end
    return SEL_W'(v);
  endfunction

  logic [3:0]          state_q, state_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [SEL_W-1:0]    who_q, who_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic                ok_q, ok_d;
  logic [SUM_W-1:0]    diff_q, diff_d;
  logic [SEL_W-1:0]    cur_q, cur_d;
  logic [PG_W-1:0]     pg_q, pg_d;
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [LINK_W-1:0]   head_q [CPU_COUNT];
  logic [LINK_W-1:0]   head_d [CPU_COUNT];
  logic [SEL_W-1:0]    seed_q, seed_d;
  logic [ADDR_W-1:0]   start_q, stop_q;
  logic [SUM_W-1:0]    base_q;
  logic                out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]   out_addr_q, out_addr_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  logic [LINK_W-1:0]   link_mem [PAGE_COUNT];
  logic [LINK_W-1:0]   link_rd_q;
  logic                link_we;
  logic [LINK_W-1:0]   cur_head;

  logic [CPU_COUNT-1:0] nonempty;
  logic [SEL_W-1:0]     lowest;
  logic [SUM_W-1:0]     page_off;
  logic [SUM_W-1:0]     diff_pages;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  pcpa_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign cur_head   = head_q[cur_q];
  assign page_off   = SUM_W'(64'(pg_q) << PAGE_SHIFT);
  assign diff_pages = diff_q >> PAGE_SHIFT;

  always_comb begin
    lowest = '0;
    for (int i = CPU_COUNT - 1; i >= 0; i--) begin
      nonempty[i] = (head_q[i] != LINK_END);
      if (head_q[i] != LINK_END) begin
        lowest = SEL_W'(i);
      end
    end
  end

  always_comb begin
    alu_req.sub = 1'b1;
    alu_req.a   = {1'b0, addr_q};
    alu_req.b   = {1'b0, start_q};
    unique case (state_q)
      S_CK_STOP: alu_req.b = {1'b0, stop_q};
      S_CK_BASE: alu_req.b = base_q;
      S_POP_WB: begin
        alu_req.sub = 1'b0;
        alu_req.a   = base_q;
        alu_req.b   = page_off;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    who_d        = who_q;
    addr_d       = addr_q;
    ok_d         = ok_q;
    diff_d       = diff_q;
    cur_d        = cur_q;
    pg_d         = pg_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    head_d       = head_q;
    seed_d       = seed_q;
    link_we      = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d       = s_axis_tuser_i;
          who_d        = cpu_mod(s_axis_tdata_i[CPU_W-1:0]);
          addr_d       = s_axis_tdata_i[CPU_W +: ADDR_W];
          res_addr_d   = '0;
          res_status_d = ST_OK;
          unique case (s_axis_tuser_i)
            KIND_ALLOC: state_d = S_SEL;
            KIND_FREE:  state_d = S_CK_START;
            KIND_SEED:  state_d = S_CK_START;
            KIND_RSVD:  state_d = S_OUT;
          endcase
        end
      end
      S_CK_START: begin
        ok_d    = alu_rsp.ge && (addr_q[PAGE_SHIFT-1:0] == '0);
        state_d = S_CK_STOP;
      end
      S_CK_STOP: begin
        ok_d    = ok_q && !alu_rsp.ge;
        state_d = S_CK_BASE;
      end
      S_CK_BASE: begin
        ok_d    = ok_q && alu_rsp.ge;
        diff_d  = alu_rsp.res;
        state_d = S_CK_RANGE;
      end
      S_CK_RANGE: begin
        pg_d  = diff_pages[PG_W-1:0];
        cur_d = (kind_q == KIND_SEED) ? seed_q : who_q;
        if (ok_q && (64'(diff_q) < PAGE_LIMIT)) begin
          state_d = S_PUSH;
        end else begin
          res_status_d = ST_BAD_ADDR;
          state_d      = S_OUT;
        end
      end
      S_PUSH: begin
        link_we       = 1'b1;
        head_d[cur_q] = LINK_W'(pg_q);
        if (kind_q == KIND_SEED) begin
          seed_d = (seed_q == SEL_W'(CPU_COUNT - 1)) ? '0 : seed_q + 1'b1;
        end
        state_d = S_OUT;
      end
      S_SEL: begin
        if (nonempty[who_q]) begin
          cur_d   = who_q;
          state_d = S_POP_RD;
        end else if (|nonempty) begin
          cur_d   = lowest;
          state_d = S_POP_RD;
        end else begin
          res_status_d = ST_OOM;
          state_d      = S_OUT;
        end
      end
      S_POP_RD: begin
        pg_d    = cur_head[PG_W-1:0];
        state_d = S_POP_WB;
      end
      S_POP_WB: begin
        head_d[cur_q] = link_rd_q;
        res_addr_d    = alu_rsp.res[ADDR_W-1:0];
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[pg_q] <= cur_head;
    end
    link_rd_q <= link_mem[cur_head[PG_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
      start_q     <= '0;
      stop_q      <= 32'h8800_0000;
      base_q      <= '0;
      for (int i = 0; i < CPU_COUNT; i++) begin
        head_q[i] <= LINK_END;
      end
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_REGION_START: begin
            start_q <= cfg_wdata_i;
            base_q  <= ({1'b0, cfg_wdata_i} + PAGE_MASK) & ~PAGE_MASK;
          end
          REG_REGION_STOP: stop_q <= cfg_wdata_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    who_q        <= who_d;
    addr_q       <= addr_d;
    ok_q         <= ok_d;
    diff_q       <= diff_d;
    cur_q        <= cur_d;
    pg_q         <= pg_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_status_q, out_addr_q};

endmodule

>>> hw/rtl/pcpa_checker.sv
// Port-level checks of the page allocator, bound to the top level.
module pcpa_checker
  import pcpa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("request taken while previous one still in flight");

  a_alloc_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i == KIND_ALLOC) |=> ##1 !s_axis_tready_o)
    else $error("allocate finished too early");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[33:32] != ST_UNUSED))
    else $error("unused status code on response");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[33:32] != ST_OK) |-> (m_axis_tdata_o[31:0] == '0))
    else $error("failed response carries an address");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled response changed");

endmodule

bind per_cpu_page_allocator_top pcpa_checker u_pcpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
